/* hw/rtl/hds_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hds_pkg: shared types and constants of the heat diffusion stencil step
// Field widths, the queue depth and the job format passed from front to back.
// ----------------------------------------------------------------------------
package hds_pkg;

  localparam int FIELD_BITS  = 32;              // sample and result field width
  localparam int RATIO_BITS  = 16;              // diffusion ratio register width
  localparam int DIFF_BITS   = FIELD_BITS + 2;  // widest neighbour difference
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // One update: result = base + floor(diff * r / 2^FRAC_BITS).
  typedef struct packed {
    logic signed [FIELD_BITS-1:0] base;
    logic signed [DIFF_BITS-1:0]  diff;
    logic                         done;
  } op_t;

  // Everything one accepted sample causes: one or two updates.
  typedef struct packed {
    op_t  first;
    op_t  second;
    logic two;
  } job_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

endpackage : hds_pkg
`default_nettype wire

/* hw/rtl/heat_diffusion_stencil_step_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_step_top: one explicit time step of 1-D heat flow
// Takes one row of Q16.16 temperatures per stream and emits the row after one
// explicit time step, with mirrored ends and saturated results.
// ----------------------------------------------------------------------------
// Usage. Samples of a row enter on the s_ stream in order, one beat each, with
// s_tlast on the last sample of the row. Results leave on the m_ stream in
// grid order, with m_tlast on the final result of the row. The first sample of
// a row yields no beat, each later sample yields the result of the point
// before it, and the last sample yields one more beat for the end point. A row
// of one sample comes back unchanged. The diffusion ratio r = dt/dx^2 is
// loaded through the cfg_ channel; the user must do so only while the block
// is idle; the block itself does not enforce this. cfg_ready is always high
// outside reset. The block takes one beat per cycle while the job queue has
// room; the update pipeline retires one result per cycle while the receiver
// takes them, and a row of N samples yields N results at the output, the
// extra end-point result taking the slot left by the row's first sample.
// Reset clears the delay line, the job queue and the pipeline, and sets r to
// zero. When the receiver stalls, the output register holds its beat, the
// pipeline stops, and the four-job queue keeps taking input until it fills;
// only then does s_tready fall.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_step_top
  import hds_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input stream: tdata = sample [31:0]; tlast = row_end.
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  input  wire logic [FIELD_BITS-1:0] s_tdata,
  input  wire logic                  s_tlast,
  // Output stream: tdata = new_value [31:0]; tlast = row_done.
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  output      logic [FIELD_BITS-1:0] m_tdata,
  output      logic                  m_tlast,
  // Configuration: cfg_data = diffusion_ratio [15:0].
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [RATIO_BITS-1:0] cfg_data
);

  // Arithmetic works at the sample width, capped at the field width.
  localparam int WORK_BITS = (SAMPLE_BITS < FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;

  logic [RATIO_BITS-1:0] diffusion_ratio;
  logic                  accept;
  logic                  push, pop;
  job_t                  push_job, head;
  queue_status_t         status;

  assign s_tready = !status.full;
  assign accept   = s_tvalid && s_tready;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      diffusion_ratio <= '0;
    end else if (cfg_valid) begin
      diffusion_ratio <= cfg_data;
    end
  end

  hds_front #(
    .WORK_BITS (WORK_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .sample  (s_tdata),
    .row_end (s_tlast),
    .push    (push),
    .job     (push_job)
  );

  hds_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (status)
  );

  hds_back #(
    .WORK_BITS (WORK_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ratio     (diffusion_ratio),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (m_tdata),
    .out_done  (m_tlast)
  );

endmodule : heat_diffusion_stencil_step_top
`default_nettype wire

/* hw/rtl/hds_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hds_front: sample intake and stencil classification
// Holds the two-sample delay line, decides which updates a sample causes and
// writes them as one job into the queue.
// ----------------------------------------------------------------------------
module hds_front
  import hds_pkg::*;
#(
  parameter int WORK_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [FIELD_BITS-1:0] sample,
  input  wire logic                  row_end,
  output      logic                  push,
  output      job_t                  job
);

  typedef enum logic [2:0] {
    ROW_START = 3'b001,
    ONE_HELD  = 3'b010,
    TWO_HELD  = 3'b100
  } seen_t;

  seen_t                        seen, seen_next;
  logic signed [FIELD_BITS-1:0] older, older_next;
  logic signed [FIELD_BITS-1:0] middle, middle_next;

  logic signed [WORK_BITS-1:0]  s_work;
  logic signed [FIELD_BITS-1:0] s;
  logic signed [DIFF_BITS-1:0]  s_d, mid_d, old_d;

  // Only the low WORK_BITS bits of a sample count, taken as signed.
  assign s_work = sample[WORK_BITS-1:0];
  assign s      = FIELD_BITS'(s_work);
  assign s_d    = DIFF_BITS'(s);
  assign mid_d  = DIFF_BITS'(middle);
  assign old_d  = DIFF_BITS'(older);

  always_comb begin
    seen_next   = seen;
    older_next  = older;
    middle_next = middle;
    push        = 1'b0;
    job         = '0;
    case (seen)
      ROW_START: begin
        if (row_end) begin
          // A row of one sample passes through unchanged.
          job.first.base = s;
          job.first.done = 1'b1;
          push           = accept;
        end else if (accept) begin
          middle_next = s;
          seen_next   = ONE_HELD;
        end
      end
      ONE_HELD, TWO_HELD: begin
        push           = accept;
        job.first.base = middle;
        if (seen == ONE_HELD) begin
          // Mirrored left end: 2r*(right - u) as r*2*(right - u).
          job.first.diff = (s_d - mid_d) <<< 1;
        end else begin
          job.first.diff = old_d + s_d - (mid_d <<< 1);
        end
        if (row_end) begin
          job.two         = 1'b1;
          job.second.base = s;
          job.second.diff = (mid_d - s_d) <<< 1;
          job.second.done = 1'b1;
          if (accept) begin
            older_next  = '0;
            middle_next = '0;
            seen_next   = ROW_START;
          end
        end else if (accept) begin
          older_next  = middle;
          middle_next = s;
          seen_next   = TWO_HELD;
        end
      end
      default: begin
        seen_next = ROW_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen   <= ROW_START;
      older  <= '0;
      middle <= '0;
    end else begin
      seen   <= seen_next;
      older  <= older_next;
      middle <= middle_next;
    end
  end

endmodule : hds_front
`default_nettype wire

/* hw/rtl/hds_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hds_queue: job queue between front and back
// A small first-in first-out buffer of jobs so that each side stalls alone.
// ----------------------------------------------------------------------------
module hds_queue
  import hds_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire job_t          push_job,
  input  wire logic          pop,
  output      job_t          head,
  output      queue_status_t status
);

  job_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push, do_pop;

  assign status.not_empty = (count != '0);
  assign status.full      = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign do_push          = push && !status.full;
  assign do_pop           = pop && status.not_empty;
  assign head             = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : hds_queue
`default_nettype wire

/* hw/rtl/hds_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hds_back: update pipeline
// Issues queued updates one per cycle unless the queue is empty or the output
// stalls, via a multiply stage and an add, floor, saturate stage into the output register.
// ----------------------------------------------------------------------------
module hds_back
  import hds_pkg::*;
#(
  parameter int WORK_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [RATIO_BITS-1:0] ratio,
  input  wire job_t                  head,
  input  wire queue_status_t         status,
  output      logic                  pop,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [FIELD_BITS-1:0] out_value,
  output      logic                  out_done
);

  localparam int PROD_BITS = DIFF_BITS + RATIO_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam logic signed [SUM_BITS-1:0] SAT_HI =
    (SUM_BITS'(1) << (WORK_BITS - 1)) - SUM_BITS'(1);
  localparam logic signed [SUM_BITS-1:0] SAT_LO = ~SAT_HI;

  logic                         sel;
  logic                         advance, issue;
  op_t                          op;
  logic signed [RATIO_BITS:0]   ratio_s;
  logic signed [PROD_BITS-1:0]  prod_next;

  logic                         m_valid;
  logic                         m_done;
  logic signed [FIELD_BITS-1:0] m_base;
  logic signed [PROD_BITS-1:0]  m_prod;

  logic signed [PROD_BITS-1:0]  scaled;
  logic signed [SUM_BITS-1:0]   sum, clamped;

  assign advance   = !out_valid || out_ready;
  assign issue     = advance && status.not_empty;
  assign pop       = issue && (!head.two || sel);
  assign op        = sel ? head.second : head.first;
  assign ratio_s   = $signed({1'b0, ratio});
  assign prod_next = op.diff * ratio_s;

  // Arithmetic shift right is the floor of the scaled product.
  assign scaled = m_prod >>> FRAC_BITS;
  assign sum    = SUM_BITS'(m_base) + SUM_BITS'(scaled);

  always_comb begin
    if (sum > SAT_HI) begin
      clamped = SAT_HI;
    end else if (sum < SAT_LO) begin
      clamped = SAT_LO;
    end else begin
      clamped = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= 1'b0;
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      if (issue) begin
        sel <= head.two && !sel;
      end
      m_valid   <= issue;
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_base    <= op.base;
      m_done    <= op.done;
      m_prod    <= prod_next;
      out_value <= clamped[FIELD_BITS-1:0];
      out_done  <= m_done;
    end
  end

endmodule : hds_back
`default_nettype wire

/* hw/rtl/hds_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hds_checker: port-level checks of the heat diffusion stencil step
// Watches reset behavior and output stalls on the top-level ports.
// ----------------------------------------------------------------------------
module hds_checker
  import hds_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [FIELD_BITS-1:0] m_tdata,
  input wire logic                  m_tlast
);

  // Reset empties the job queue and clears both pipeline valid registers, so a
  // result beat cannot appear until a job has passed through both registers.
  a_no_early_result : assert property (@(posedge clk)
    rst |=> !m_tvalid ##1 !m_tvalid)
    else $error("result beat too soon after reset");

  // The queue is empty after reset, so input and configuration are open.
  a_ready_after_reset : assert property (@(posedge clk)
    rst |=> s_tready || rst)
    else $error("input not ready after reset");

  // A stalled result beat holds.
  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result beat changed");

endmodule : hds_checker

bind heat_diffusion_stencil_step_top hds_checker u_hds_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast)
);
`default_nettype wire
